FILE: design/slts_pkg.sv
`default_nettype none

package slts_pkg;

  // Offset counters (position, token start) width.
  localparam int OffsetBits = 16;
  localparam logic [15:0] FieldMax = 16'hFFFF;
  localparam logic [OffsetBits-1:0] OffsetMax = {OffsetBits{1'b1}};

  // Slots in the result queue.
  localparam int QueueDepth = 4;

  // Lexer modes.
  localparam logic [3:0] ModeIdle    = 4'd0;
  localparam logic [3:0] ModeBang    = 4'd1;
  localparam logic [3:0] ModeEq      = 4'd2;
  localparam logic [3:0] ModeGt      = 4'd3;
  localparam logic [3:0] ModeLt      = 4'd4;
  localparam logic [3:0] ModeSlash   = 4'd5;
  localparam logic [3:0] ModeComment = 4'd6;
  localparam logic [3:0] ModeString  = 4'd7;
  localparam logic [3:0] ModeInt     = 4'd8;
  localparam logic [3:0] ModeDot     = 4'd9;
  localparam logic [3:0] ModeFrac    = 4'd10;
  localparam logic [3:0] ModeIdent   = 4'd11;

  // Token kinds.
  localparam logic [4:0] KLParen  = 5'd0;
  localparam logic [4:0] KRParen  = 5'd1;
  localparam logic [4:0] KLBrace  = 5'd2;
  localparam logic [4:0] KRBrace  = 5'd3;
  localparam logic [4:0] KComma   = 5'd4;
  localparam logic [4:0] KDot     = 5'd5;
  localparam logic [4:0] KMinus   = 5'd6;
  localparam logic [4:0] KPlus    = 5'd7;
  localparam logic [4:0] KSemi    = 5'd8;
  localparam logic [4:0] KSlash   = 5'd9;
  localparam logic [4:0] KStar    = 5'd10;
  localparam logic [4:0] KBang    = 5'd11;
  localparam logic [4:0] KBangEq  = 5'd12;
  localparam logic [4:0] KEq      = 5'd13;
  localparam logic [4:0] KEqEq    = 5'd14;
  localparam logic [4:0] KGt      = 5'd15;
  localparam logic [4:0] KGtEq    = 5'd16;
  localparam logic [4:0] KLt      = 5'd17;
  localparam logic [4:0] KLtEq    = 5'd18;
  localparam logic [4:0] KString  = 5'd19;
  localparam logic [4:0] KNumber  = 5'd20;
  localparam logic [4:0] KIdent   = 5'd21;
  localparam logic [4:0] KEnd     = 5'd22;
  localparam logic [4:0] KBadChar = 5'd23;
  localparam logic [4:0] KUnterm  = 5'd24;

  // Characters.
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChLBrace = 8'h7B;
  localparam logic [7:0] ChRBrace = 8'h7D;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChUnder  = 8'h5F;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        last;
  } out_item_t;

  // Outcome of scanning a byte from the idle mode.
  typedef struct packed {
    logic       emit;
    logic [4:0] kind;
    logic [3:0] mode;
    logic       newline;
  } fresh_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == ChUnder);
  endfunction

  function automatic fresh_t fresh_scan(input logic [7:0] c);
    fresh_t f;
    f = '{emit: 1'b1, kind: KBadChar, mode: ModeIdle, newline: 1'b0};
    case (c)
      ChLParen: f.kind = KLParen;
      ChRParen: f.kind = KRParen;
      ChLBrace: f.kind = KLBrace;
      ChRBrace: f.kind = KRBrace;
      ChComma:  f.kind = KComma;
      ChDot:    f.kind = KDot;
      ChMinus:  f.kind = KMinus;
      ChPlus:   f.kind = KPlus;
      ChSemi:   f.kind = KSemi;
      ChStar:   f.kind = KStar;
      ChBang:   begin f.emit = 1'b0; f.mode = ModeBang;   end
      ChEq:     begin f.emit = 1'b0; f.mode = ModeEq;     end
      ChGt:     begin f.emit = 1'b0; f.mode = ModeGt;     end
      ChLt:     begin f.emit = 1'b0; f.mode = ModeLt;     end
      ChSlash:  begin f.emit = 1'b0; f.mode = ModeSlash;  end
      ChQuote:  begin f.emit = 1'b0; f.mode = ModeString; end
      ChSpace, ChCr, ChTab: f.emit = 1'b0;
      ChNl:     begin f.emit = 1'b0; f.newline = 1'b1;    end
      default: begin
        if (is_digit(c)) begin
          f.emit = 1'b0;
          f.mode = ModeInt;
        end else if (is_alpha(c)) begin
          f.emit = 1'b0;
          f.mode = ModeIdent;
        end
      end
    endcase
    return f;
  endfunction

  // One-byte kind of a pending comparison operator; its two-byte form is one more.
  function automatic logic [4:0] op_kind(input logic [3:0] m);
    logic [4:0] k;
    case (m)
      ModeBang: k = KBang;
      ModeEq:   k = KEq;
      ModeGt:   k = KGt;
      default:  k = KLt;
    endcase
    return k;
  endfunction

  function automatic logic [15:0] sat_field(input logic [OffsetBits:0] v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'(FieldMax)) ? FieldMax : w[15:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/script_lexer_token_stream.sv
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        sink       in_valid_i / in_ready_o   in_data_i  (slts_pkg::in_item_t)
// out       source     out_valid_o / out_ready_i out_data_o (slts_pkg::out_item_t)
//
// One source byte per cycle: the lexer state updates in the cycle the input
// transaction is taken, and its tokens (zero to three) enter a four-slot
// result queue whose head drives the output. The queue drains one token per
// cycle while the receiver is ready; input is taken only while the queue
// holds at most one token.
// Reset clears the mode, the offsets, the line count (to one) and the queue.
module script_lexer_token_stream (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire slts_pkg::in_item_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output slts_pkg::out_item_t       out_data_o
);

  localparam int Ob = slts_pkg::OffsetBits;
  localparam int Qd = slts_pkg::QueueDepth;

  // Lexer state.
  logic [3:0]    mode_q, mode_d;
  logic [Ob-1:0] start_q, start_d;
  logic [Ob-1:0] pos_q, pos_d;
  logic [15:0]   line_q, line_d;

  // Result queue, head in slot 0.
  slts_pkg::out_item_t slot_q [Qd];
  slts_pkg::out_item_t slot_d [Qd];
  logic [2:0]          cnt_q, cnt_d;

  // Tokens produced by the current transaction.
  slts_pkg::out_item_t tok [3];
  logic [1:0]          ntok;

  logic           accept, pop;
  logic [7:0]     c;
  slts_pkg::fresh_t fr;
  logic [Ob:0]    span, span1, dspan;
  logic [Ob-1:0]  pdec;

  assign accept      = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign in_ready_o  = (cnt_q <= 3'd1);
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o  = slot_q[0];

  assign c     = in_data_i.char_code;
  assign fr    = slts_pkg::fresh_scan(c);
  assign pdec  = (pos_q != '0) ? pos_q - 1'b1 : '0;
  assign span  = {1'b0, pos_q} - {1'b0, start_q};
  assign span1 = span + 1'b1;
  // Number part of a trailing dot; zero when the number starts at the
  // saturated offset and the dot would land before it.
  assign dspan = (pdec >= start_q) ? {1'b0, pdec} - {1'b0, start_q} : '0;

  // Scan one transaction: collect its tokens in order and form the next state.
  always_comb begin
    logic do_flush, do_fresh, is_end;
    logic [3:0] m;
    do_flush = 1'b0;
    do_fresh = 1'b0;
    is_end   = in_data_i.kind;
    m        = mode_q;
    mode_d   = mode_q;
    start_d  = start_q;
    pos_d    = pos_q;
    line_d   = line_q;
    ntok     = 2'd0;
    for (int i = 0; i < 3; i++) begin
      tok[i] = '0;
    end

    if (is_end) begin
      if (m == slts_pkg::ModeString) begin
        tok[ntok] = '{slts_pkg::KUnterm, slts_pkg::sat_field({1'b0, start_q}),
                      slts_pkg::sat_field(span), line_q, 1'b0};
        ntok = ntok + 2'd1;
      end else begin
        do_flush = 1'b1;
      end
    end else begin
      case (m)
        slts_pkg::ModeBang, slts_pkg::ModeEq, slts_pkg::ModeGt, slts_pkg::ModeLt: begin
          if (c == slts_pkg::ChEq) begin
            tok[ntok] = '{slts_pkg::op_kind(m) + 5'd1,
                          slts_pkg::sat_field({1'b0, start_q}),
                          slts_pkg::sat_field(span1), line_q, 1'b0};
            ntok = ntok + 2'd1;
            mode_d = slts_pkg::ModeIdle;
          end else begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
          end
        end
        slts_pkg::ModeSlash: begin
          if (c == slts_pkg::ChSlash) begin
            mode_d = slts_pkg::ModeComment;
          end else begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
          end
        end
        slts_pkg::ModeComment: begin
          do_fresh = (c == slts_pkg::ChNl);
        end
        slts_pkg::ModeString: begin
          if (c == slts_pkg::ChNl && line_q != slts_pkg::FieldMax) begin
            line_d = line_q + 16'd1;
          end
          if (c == slts_pkg::ChQuote) begin
            tok[ntok] = '{slts_pkg::KString, slts_pkg::sat_field({1'b0, start_q}),
                          slts_pkg::sat_field(span1), line_q, 1'b0};
            ntok = ntok + 2'd1;
            mode_d = slts_pkg::ModeIdle;
          end
        end
        slts_pkg::ModeInt: begin
          if (c == slts_pkg::ChDot) begin
            mode_d = slts_pkg::ModeDot;
          end else if (!slts_pkg::is_digit(c)) begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
          end
        end
        slts_pkg::ModeDot: begin
          if (slts_pkg::is_digit(c)) begin
            mode_d = slts_pkg::ModeFrac;
          end else begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
          end
        end
        slts_pkg::ModeFrac: begin
          if (!slts_pkg::is_digit(c)) begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
          end
        end
        slts_pkg::ModeIdent: begin
          if (!slts_pkg::is_digit(c) && !slts_pkg::is_alpha(c)) begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
          end
        end
        default: begin
          do_fresh = 1'b1;
        end
      endcase
    end

    // Pending token of the old mode, cut at the current position.
    if (do_flush) begin
      mode_d = slts_pkg::ModeIdle;
      case (m)
        slts_pkg::ModeBang, slts_pkg::ModeEq, slts_pkg::ModeGt, slts_pkg::ModeLt: begin
          tok[ntok] = '{slts_pkg::op_kind(m), slts_pkg::sat_field({1'b0, start_q}),
                        16'd1, line_q, 1'b0};
          ntok = ntok + 2'd1;
        end
        slts_pkg::ModeSlash: begin
          tok[ntok] = '{slts_pkg::KSlash, slts_pkg::sat_field({1'b0, start_q}),
                        16'd1, line_q, 1'b0};
          ntok = ntok + 2'd1;
        end
        slts_pkg::ModeInt, slts_pkg::ModeFrac: begin
          tok[ntok] = '{slts_pkg::KNumber, slts_pkg::sat_field({1'b0, start_q}),
                        slts_pkg::sat_field(span), line_q, 1'b0};
          ntok = ntok + 2'd1;
        end
        slts_pkg::ModeDot: begin
          // Trailing dot: number up to the dot, then the dot itself.
          tok[ntok] = '{slts_pkg::KNumber, slts_pkg::sat_field({1'b0, start_q}),
                        slts_pkg::sat_field(dspan), line_q, 1'b0};
          ntok = ntok + 2'd1;
          tok[ntok] = '{slts_pkg::KDot, slts_pkg::sat_field({1'b0, pdec}),
                        16'd1, line_q, 1'b0};
          ntok = ntok + 2'd1;
        end
        slts_pkg::ModeIdent: begin
          tok[ntok] = '{slts_pkg::KIdent, slts_pkg::sat_field({1'b0, start_q}),
                        slts_pkg::sat_field(span), line_q, 1'b0};
          ntok = ntok + 2'd1;
        end
        default: begin
        end
      endcase
    end

    // Rescan the byte from idle.
    if (do_fresh) begin
      start_d = pos_q;
      mode_d  = fr.mode;
      if (fr.newline && line_q != slts_pkg::FieldMax) begin
        line_d = line_q + 16'd1;
      end
      if (fr.emit) begin
        tok[ntok] = '{fr.kind, slts_pkg::sat_field({1'b0, pos_q}), 16'd1, line_q, 1'b0};
        ntok = ntok + 2'd1;
      end
    end

    if (is_end) begin
      tok[ntok] = '{slts_pkg::KEnd, slts_pkg::sat_field({1'b0, pos_q}), 16'd0, line_q, 1'b0};
      ntok = ntok + 2'd1;
      mode_d  = slts_pkg::ModeIdle;
      start_d = '0;
      pos_d   = '0;
      line_d  = 16'd1;
    end else if (pos_q != slts_pkg::OffsetMax) begin
      pos_d = pos_q + 1'b1;
    end

    // Mark the final token of this transaction.
    for (int i = 0; i < 3; i++) begin
      tok[i].last = (2'(i) == ntok - 2'd1);
    end
  end

  // Queue update: shift on pop, append new tokens behind what remains.
  always_comb begin
    logic [2:0] base, rel;
    logic [2:0] npush;
    base  = cnt_q - {2'b00, pop};
    npush = accept ? {1'b0, ntok} : 3'd0;
    for (int i = 0; i < Qd; i++) begin
      if (pop && i < Qd - 1) begin
        slot_d[i] = slot_q[i+1];
      end else begin
        slot_d[i] = slot_q[i];
      end
      rel = 3'(i) - base;
      if (3'(i) >= base && rel < npush) begin
        slot_d[i] = tok[rel[1:0]];
      end
    end
    cnt_d = base + npush;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= slts_pkg::ModeIdle;
      start_q <= '0;
      pos_q   <= '0;
      line_q  <= 16'd1;
      cnt_q   <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        mode_q  <= mode_d;
        start_q <= start_d;
        pos_q   <= pos_d;
        line_q  <= line_d;
      end
    end
  end

  // Payload slots hold without reset.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Qd; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

`ifndef SYNTHESIS
  // Queue never overfills.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'(Qd))
    else $error("result queue overflow");

  // End of input returns the lexer to its reset state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.kind) |=>
      (mode_q == slts_pkg::ModeIdle && pos_q == '0 && line_q == 16'd1))
    else $error("lexer state not cleared after end of input");

  // A token that is not the last of its transaction has its successor queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.last) |-> (cnt_q >= 3'd2))
    else $error("non-final token without successor in queue");
`endif

endmodule

`default_nettype wire

FILE: sim/script_lexer_token_stream_tb.sv
`timescale 1ns / 100ps

module script_lexer_token_stream_tb;

  localparam int MaxGap      = 15;
  localparam int TailCycles  = 20;
  localparam int RandomItems = 370;
  localparam int HoldCycles  = 300;
  localparam int TimeoutNs   = 5_000_000;
  localparam int MaxPrinted  = 40;

  // Shapes of random lexemes; the open string ends the source it lands in.
  typedef enum int {
    LxPunct, LxCompare, LxSlash, LxComment, LxString, LxInt, LxFrac,
    LxTrailDot, LxIdent, LxBlank, LxBadByte, LxAnyByte, LxOpenString, LxCount
  } lexeme_shape_e;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  slts_pkg::in_item_t  in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  slts_pkg::out_item_t out_data_o;

  script_lexer_token_stream u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Shared run state: random gaps on both sides, the long receiver hold-off,
  // the mismatch count and the number of input transactions so far.
  logic idle_on = 1'b1;
  int   hold_left = 0;
  int   errors = 0;
  int   sent = 0;

  string digit_set = "0123456789";
  string word_head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string word_body = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string blank_set = " \t\015\n";

  // ---------------------------------------------------------------------------
  // Token predictor: own copy of the scanner state, updated once per accepted
  // input transaction. Tokens of one step gather in step_toks, then move to
  // tokens_due in emission order.
  // ---------------------------------------------------------------------------
  logic [3:0]          lex_mode;
  logic [15:0]         tok_start;
  logic [15:0]         src_pos;    // offset of the next byte to arrive
  logic [15:0]         line_cnt;
  slts_pkg::out_item_t step_toks[$];
  slts_pkg::out_item_t tokens_due[$];

  function automatic void reset_lexer();
    lex_mode  = slts_pkg::ModeIdle;
    tok_start = '0;
    src_pos   = '0;
    line_cnt  = 16'd1;
  endfunction

  function automatic logic [15:0] clip16(input logic [16:0] v);
    return (v > {1'b0, slts_pkg::FieldMax}) ? slts_pkg::FieldMax : v[15:0];
  endfunction

  // Distance from a to b, never negative (offsets stall once saturated).
  function automatic logic [16:0] span(input logic [15:0] a, input logic [15:0] b);
    return (b >= a) ? {1'b0, b} - {1'b0, a} : 17'd0;
  endfunction

  function automatic logic is_num_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_word_start(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == slts_pkg::ChUnder;
  endfunction

  // One-byte kind of a pending comparison; the two-byte form is the next kind.
  function automatic logic [4:0] cmp_kind(input logic [3:0] m);
    case (m)
      slts_pkg::ModeBang: return slts_pkg::KBang;
      slts_pkg::ModeEq:   return slts_pkg::KEq;
      slts_pkg::ModeGt:   return slts_pkg::KGt;
      default:            return slts_pkg::KLt;
    endcase
  endfunction

  // Drop anything past three tokens in one step.
  function automatic void push_token(input logic [4:0] k, input logic [15:0] start,
                                     input logic [16:0] len);
    slts_pkg::out_item_t t;
    if (step_toks.size() < 3) begin
      t.token_kind   = k;
      t.start_offset = start;
      t.token_length = clip16(len);
      t.line_number  = line_cnt;
      t.last         = 1'b0;
      step_toks.insert(step_toks.size(), t);
    end
  endfunction

  function automatic void bump_line();
    if (line_cnt != slts_pkg::FieldMax) line_cnt++;
  endfunction

  // Scan a byte from the idle mode: emit single-byte tokens, open the others.
  function automatic void open_lexeme(input logic [7:0] c, input logic [15:0] p);
    tok_start = p;
    lex_mode  = slts_pkg::ModeIdle;
    case (c)
      slts_pkg::ChLParen: push_token(slts_pkg::KLParen, p, 17'd1);
      slts_pkg::ChRParen: push_token(slts_pkg::KRParen, p, 17'd1);
      slts_pkg::ChLBrace: push_token(slts_pkg::KLBrace, p, 17'd1);
      slts_pkg::ChRBrace: push_token(slts_pkg::KRBrace, p, 17'd1);
      slts_pkg::ChComma:  push_token(slts_pkg::KComma, p, 17'd1);
      slts_pkg::ChDot:    push_token(slts_pkg::KDot, p, 17'd1);
      slts_pkg::ChMinus:  push_token(slts_pkg::KMinus, p, 17'd1);
      slts_pkg::ChPlus:   push_token(slts_pkg::KPlus, p, 17'd1);
      slts_pkg::ChSemi:   push_token(slts_pkg::KSemi, p, 17'd1);
      slts_pkg::ChStar:   push_token(slts_pkg::KStar, p, 17'd1);
      slts_pkg::ChBang:   lex_mode = slts_pkg::ModeBang;
      slts_pkg::ChEq:     lex_mode = slts_pkg::ModeEq;
      slts_pkg::ChGt:     lex_mode = slts_pkg::ModeGt;
      slts_pkg::ChLt:     lex_mode = slts_pkg::ModeLt;
      slts_pkg::ChSlash:  lex_mode = slts_pkg::ModeSlash;
      slts_pkg::ChQuote:  lex_mode = slts_pkg::ModeString;
      slts_pkg::ChSpace, slts_pkg::ChCr, slts_pkg::ChTab: ;
      slts_pkg::ChNl:     bump_line();
      default: begin
        if (is_num_char(c)) lex_mode = slts_pkg::ModeInt;
        else if (is_word_start(c)) lex_mode = slts_pkg::ModeIdent;
        else push_token(slts_pkg::KBadChar, p, 17'd1);
      end
    endcase
  endfunction

  // Emit the token held open by the current mode, cut at offset p.
  function automatic void close_pending(input logic [15:0] p);
    logic [15:0] d;
    d = (p != 16'd0) ? p - 16'd1 : 16'd0;
    case (lex_mode)
      slts_pkg::ModeBang, slts_pkg::ModeEq, slts_pkg::ModeGt, slts_pkg::ModeLt:
        push_token(cmp_kind(lex_mode), tok_start, 17'd1);
      slts_pkg::ModeSlash: push_token(slts_pkg::KSlash, tok_start, 17'd1);
      slts_pkg::ModeInt, slts_pkg::ModeFrac:
        push_token(slts_pkg::KNumber, tok_start, span(tok_start, p));
      slts_pkg::ModeDot: begin
        // the dot was not followed by a digit: number, then a separate dot
        push_token(slts_pkg::KNumber, tok_start, span(tok_start, d));
        push_token(slts_pkg::KDot, d, 17'd1);
      end
      slts_pkg::ModeIdent: push_token(slts_pkg::KIdent, tok_start, span(tok_start, p));
      default: ;
    endcase
    lex_mode = slts_pkg::ModeIdle;
  endfunction

  function automatic void restart(input logic [7:0] c, input logic [15:0] p);
    close_pending(p);
    open_lexeme(c, p);
  endfunction

  function automatic void predict_tokens(input slts_pkg::in_item_t it);
    logic [15:0] p;
    logic [7:0]  c;
    p = src_pos;
    c = it.char_code;
    step_toks.delete();
    if (it.kind) begin
      // end of input: flush or report the open string, then the end token
      if (lex_mode == slts_pkg::ModeString) begin
        push_token(slts_pkg::KUnterm, tok_start, span(tok_start, p));
        lex_mode = slts_pkg::ModeIdle;
      end else begin
        close_pending(p);
      end
      push_token(slts_pkg::KEnd, p, 17'd0);
      reset_lexer();
    end else begin
      case (lex_mode)
        slts_pkg::ModeBang, slts_pkg::ModeEq, slts_pkg::ModeGt, slts_pkg::ModeLt: begin
          if (c == slts_pkg::ChEq) begin
            push_token(cmp_kind(lex_mode) + 5'd1, tok_start, span(tok_start, p) + 17'd1);
            lex_mode = slts_pkg::ModeIdle;
          end else begin
            restart(c, p);
          end
        end
        slts_pkg::ModeSlash: begin
          if (c == slts_pkg::ChSlash) lex_mode = slts_pkg::ModeComment;
          else restart(c, p);
        end
        slts_pkg::ModeComment: begin
          if (c == slts_pkg::ChNl) open_lexeme(c, p);
        end
        slts_pkg::ModeString: begin
          if (c == slts_pkg::ChNl) bump_line();
          if (c == slts_pkg::ChQuote) begin
            push_token(slts_pkg::KString, tok_start, span(tok_start, p) + 17'd1);
            lex_mode = slts_pkg::ModeIdle;
          end
        end
        slts_pkg::ModeInt: begin
          if (c == slts_pkg::ChDot) lex_mode = slts_pkg::ModeDot;
          else if (!is_num_char(c)) restart(c, p);
        end
        slts_pkg::ModeDot: begin
          if (is_num_char(c)) lex_mode = slts_pkg::ModeFrac;
          else restart(c, p);
        end
        slts_pkg::ModeFrac: begin
          if (!is_num_char(c)) restart(c, p);
        end
        slts_pkg::ModeIdent: begin
          if (!(is_word_start(c) || is_num_char(c))) restart(c, p);
        end
        default: open_lexeme(c, p);
      endcase
      if (src_pos != slts_pkg::OffsetMax) src_pos++;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) tokens_due.insert(tokens_due.size(), step_toks[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    if (errors <= MaxPrinted)
      $display("%0t: token mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_token(input slts_pkg::out_item_t got);
    slts_pkg::out_item_t want;
    if (tokens_due.size() == 0) begin
      report("token_kind of a token with none due", 32'(got.token_kind), 32'd0);
      return;
    end
    want = tokens_due.pop_front();
    if (got.token_kind != want.token_kind)
      report("token_kind", 32'(got.token_kind), 32'(want.token_kind));
    if (got.start_offset != want.start_offset)
      report("start_offset", 32'(got.start_offset), 32'(want.start_offset));
    if (got.token_length != want.token_length)
      report("token_length", 32'(got.token_length), 32'(want.token_length));
    if (got.line_number != want.line_number)
      report("line_number", 32'(got.line_number), 32'(want.line_number));
    if (got.last != want.last)
      report("last", 32'(got.last), 32'(want.last));
  endtask

  // Receiver: check every output transaction against the oldest due token,
  // then, when random gaps are on, hold ready low for a random number of cycles.
  // A long hold-off, when requested, is counted down here and overrides the per-token stall.
  initial begin : drain
    int stall;
    stall = 0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        check_token(out_data_o);
        stall = idle_on ? $urandom_range(0, MaxGap) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offer one input transaction and hold it until taken. Entered and left at a
  // rising edge; valid stays high straight into the next item when no gap is
  // drawn.
  task automatic send_item(input logic kind, input logic [7:0] ch);
    slts_pkg::in_item_t it;
    int gap;
    it.kind      = kind;
    it.char_code = ch;
    gap = idle_on ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predict_tokens(it);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  task automatic send_eof();
    send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] pick(input string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  logic [7:0] src_bytes[$];

  function automatic void add_byte(input logic [7:0] b);
    src_bytes.insert(src_bytes.size(), b);
  endfunction

  // Append one random lexeme to src_bytes; return 1 when it leaves a string
  // open, so the source must end there.
  function automatic logic add_lexeme();
    lexeme_shape_e shape;
    int            n;
    logic [7:0]    b;
    shape = lexeme_shape_e'($urandom_range(0, LxCount - 1));
    n = $urandom_range(0, 6);
    case (shape)
      LxPunct: add_byte(pick("(){},.-+;*"));
      LxCompare: begin
        add_byte(pick("!=<>"));
        if ($urandom_range(0, 1)) add_byte(slts_pkg::ChEq);
      end
      LxSlash: add_byte(slts_pkg::ChSlash);
      LxComment: begin
        add_byte(slts_pkg::ChSlash);
        add_byte(slts_pkg::ChSlash);
        repeat (n) begin
          b = 8'($urandom_range(0, 255));
          add_byte(b == slts_pkg::ChNl ? slts_pkg::ChSpace : b);
        end
        // usually closed by a newline, sometimes cut by end of input
        if ($urandom_range(0, 3) != 0) add_byte(slts_pkg::ChNl);
      end
      LxString, LxOpenString: begin
        add_byte(slts_pkg::ChQuote);
        repeat (n) begin
          b = ($urandom_range(0, 3) == 0) ? slts_pkg::ChNl : 8'($urandom_range(0, 255));
          add_byte(b == slts_pkg::ChQuote ? slts_pkg::ChSpace : b);
        end
        if (shape == LxOpenString) return 1'b1;
        add_byte(slts_pkg::ChQuote);
      end
      LxInt: repeat (n + 1) add_byte(pick(digit_set));
      LxFrac, LxTrailDot: begin
        repeat (n + 1) add_byte(pick(digit_set));
        add_byte(slts_pkg::ChDot);
        if (shape == LxFrac) repeat ($urandom_range(1, 4)) add_byte(pick(digit_set));
      end
      LxIdent: begin
        add_byte(pick(word_head));
        repeat (n) add_byte(pick(word_body));
      end
      LxBlank: add_byte(pick(blank_set));
      LxBadByte: begin
        if ($urandom_range(0, 1)) add_byte(8'($urandom_range(128, 255)));
        else add_byte(pick("#@$%^&~`?:[]|\\'"));
      end
      default: add_byte(8'($urandom_range(0, 255)));
    endcase
    return 1'b0;
  endfunction

  // Short hand-written source: identifiers, two-byte operators, a comment
  // closed by a newline, a string spanning lines, a fraction, a trailing dot
  // that splits into number, dot and semicolon, a byte above 127, end.
  task automatic test_directed();
    idle_on = 1'b1;
    send_text("a<=b!=c//z\n\"s\n\"1.5 9.;");
    send_item(1'b0, 8'hC8);
    send_eof();
  endtask

  // Stall the receiver for a long stretch while the sender keeps offering
  // bytes, some of which end three tokens at once, so the result queue fills
  // and the input side backs up.
  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_left = HoldCycles;
    send_text("(1.;)(1.;)(1.;)(1.;)(1.;)(1.;)");
    send_eof();
  endtask

  // Random sources built mostly from well-formed lexemes, with noise bytes
  // mixed in; each source is closed by end of input, often mid-token.
  task automatic test_random();
    int   first;
    logic open_str;
    first = sent;
    while (sent - first < RandomItems) begin
      idle_on = ($urandom_range(0, 3) != 0);
      src_bytes.delete();
      open_str = 1'b0;
      repeat ($urandom_range(1, 10)) begin
        if (!open_str) begin
          open_str = add_lexeme();
          if (!open_str && $urandom_range(0, 1)) add_byte(pick(blank_set));
        end
      end
      foreach (src_bytes[i]) send_item(1'b0, src_bytes[i]);
      send_eof();
    end
  endtask

  initial begin : stimulus
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    reset_lexer();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_random();

    // Drop valid, let every due token drain, then keep watching for stray output.
    in_valid_i <= 1'b0;
    idle_on = 1'b1;
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("script_lexer_token_stream_tb: clean");
    end else begin
      $display("script_lexer_token_stream_tb: errors");
    end
    $finish;
  end

  // Catch a hung handshake on either side.
  initial begin : watchdog
    #TimeoutNs;
    $display("script_lexer_token_stream_tb: errors");
    $finish;
  end

endmodule
